// ===== rtl/tara_pkg.sv =====
// Shared types and constants of the tensor axis reorder address block.
// No dependencies; every rtl file uses this package.
package tara_pkg;

	localparam int NUM_AXES = 4;
	localparam int AXIS_SLOT = 16;
	localparam int AXIS_W = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam int RANK_LIMIT_DEF = 4;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int INDEX_BITS_DEF = 32;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_RANK         = 3'd1,
		REG_AXIS_LENGTHS = 3'd2,
		REG_AXIS_ORDER   = 3'd3,
		REG_REFLECT_MASK = 3'd4,
		REG_ROTATE_AXES  = 3'd5,
		REG_SCALE        = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PERMUTE = 2'd0,
		MODE_REFLECT = 2'd1,
		MODE_ROT90   = 2'd2,
		MODE_ROT180  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [2:0]         rank;
		logic [63:0]        axis_lengths;
		logic [7:0]         axis_order;
		logic [3:0]         reflect_mask;
		logic [3:0]         rotate_axes;
		logic signed [31:0] scale;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:         MODE_PERMUTE,
		rank:         3'd1,
		axis_lengths: 64'h0001_0001_0001_0001,
		axis_order:   8'd228,
		reflect_mask: 4'd0,
		rotate_axes:  4'd4,
		scale:        32'sh4000_0000
	};

	// per-item flags decided by the front end
	typedef struct packed {
		logic rot_err;
		logic last;
		logic scale_en;
	} entry_flags_t;

	localparam logic signed [63:0] ROUND_HALF = 64'sh2000_0000;
	localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/tara_front.sv =====
// Front end: takes sample transfers, runs the per-axis coordinate counters and
// works out destination coordinates, shape and flags. Uses tara_pkg.
module tara_front #(
	parameter int RANK_LIMIT  = tara_pkg::RANK_LIMIT_DEF,
	parameter int LENGTH_BITS = tara_pkg::LENGTH_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  tara_pkg::cfg_t                                   cfg,
	input  logic                                             cfg_clear,
	input  logic                                             sample_valid,
	output logic                                             sample_stall,
	input  logic                                             queue_full,
	output logic                                             push,
	output logic [tara_pkg::NUM_AXES-1:0][LENGTH_BITS-1:0]   dc,
	output logic [tara_pkg::NUM_AXES-1:0][LENGTH_BITS-1:0]   dl,
	output tara_pkg::entry_flags_t                           flags
);
	import tara_pkg::*;

	localparam int RANK_CAP = (RANK_LIMIT < NUM_AXES) ? RANK_LIMIT : NUM_AXES;

	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] coord_q;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] coord_nxt;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] len_raw;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] c;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] l;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] lmax;
	logic [NUM_AXES-1:0][AXIS_W-1:0]      perm_src;
	logic [NUM_AXES-1:0]                  act;
	logic [NUM_AXES-1:0]                  at_max;
	logic [2:0]                           rank_eff;
	logic [AXIS_W-1:0]                    a1;
	logic [AXIS_W-1:0]                    a2;
	logic                                 a1_in;
	logic                                 a2_in;
	logic                                 rot_err;
	logic                                 carry;

	assign sample_stall = queue_full;
	assign push = sample_valid && !queue_full;

	always_comb begin
		if (cfg.rank == 3'd0) begin
			rank_eff = 3'd1;
		end else if (cfg.rank > 3'(RANK_CAP)) begin
			rank_eff = 3'(RANK_CAP);
		end else begin
			rank_eff = cfg.rank;
		end
	end

	// axes past the rank look like length 1 at coordinate 0
	always_comb begin
		for (int d = 0; d < NUM_AXES; d++) begin
			len_raw[d] = cfg.axis_lengths[AXIS_SLOT*d +: LENGTH_BITS];
			act[d] = (3'(d) < rank_eff);
			c[d] = act[d] ? coord_q[d] : '0;
			if (!act[d] || len_raw[d] == '0) begin
				l[d] = LENGTH_BITS'(1);
			end else begin
				l[d] = len_raw[d];
			end
			lmax[d] = l[d] - LENGTH_BITS'(1);
			at_max[d] = (c[d] == lmax[d]);
			if ({1'b0, cfg.axis_order[AXIS_W*d +: AXIS_W]} < rank_eff) begin
				perm_src[d] = cfg.axis_order[AXIS_W*d +: AXIS_W];
			end else begin
				perm_src[d] = AXIS_W'(d);
			end
		end
	end

	assign a1 = cfg.rotate_axes[1:0];
	assign a2 = cfg.rotate_axes[3:2];
	assign a1_in = ({1'b0, a1} < rank_eff);
	assign a2_in = ({1'b0, a2} < rank_eff);

	always_comb begin
		dc = c;
		dl = l;
		rot_err = 1'b0;
		unique case (cfg.mode)
			MODE_PERMUTE: begin
				for (int d = 0; d < NUM_AXES; d++) begin
					if (act[d]) begin
						dc[d] = c[perm_src[d]];
						dl[d] = l[perm_src[d]];
					end
				end
			end
			MODE_REFLECT: begin
				for (int d = 0; d < NUM_AXES; d++) begin
					if (act[d] && cfg.reflect_mask[d]) begin
						dc[d] = lmax[d] - c[d];
					end
				end
			end
			MODE_ROT90: begin
				if (a1_in && a2_in && a1 != a2) begin
					if (l[a1] != l[a2]) begin
						rot_err = 1'b1;
					end else begin
						dc[a1] = c[a2];
						dc[a2] = lmax[a2] - c[a1];
					end
				end
			end
			MODE_ROT180: begin
				if (a1_in && a2_in) begin
					dc[a1] = lmax[a1] - c[a1];
					dc[a2] = lmax[a2] - c[a2];
				end
			end
			default: ;
		endcase
	end

	assign flags = '{
		rot_err:  rot_err,
		last:     &at_max,
		scale_en: (cfg.mode == MODE_PERMUTE) || (cfg.mode == MODE_REFLECT)
	};

	// row-major step: last active axis runs fastest
	always_comb begin
		carry = 1'b1;
		for (int d = NUM_AXES - 1; d >= 0; d--) begin
			coord_nxt[d] = coord_q[d];
			if (act[d] && carry) begin
				coord_nxt[d] = at_max[d] ? '0 : c[d] + LENGTH_BITS'(1);
			end
			carry = carry & at_max[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (cfg_clear) begin
			coord_q <= '0;
		end else if (push) begin
			coord_q <= coord_nxt;
		end
	end

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && flags.last && !cfg_clear |=> coord_q == '0)
		else $error("coordinates did not wrap after the last element");

	a_clear_on_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clear |=> coord_q == '0)
		else $error("coordinates not cleared by a register write");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		push && !flags.last && !cfg_clear |=> coord_q != $past(coord_q))
		else $error("coordinate counter did not advance");

endmodule

// ===== rtl/tara_queue.sv =====
// Short register queue between the front end and the back end.
// Generic data width; uses tara_pkg only for its default depth.
module tara_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tara_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic             full
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tara_back.sv =====
// Back end: four-stage pipeline that forms the row-major index, scales the
// value and holds the result register. Uses tara_pkg.
module tara_back #(
	parameter int LENGTH_BITS = tara_pkg::LENGTH_BITS_DEF,
	parameter int INDEX_BITS  = tara_pkg::INDEX_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic signed [31:0]                               scale,
	input  logic                                             q_valid,
	output logic                                             q_pop,
	input  logic [tara_pkg::NUM_AXES-1:0][LENGTH_BITS-1:0]   q_dc,
	input  logic [tara_pkg::NUM_AXES-1:0][LENGTH_BITS-1:0]   q_dl,
	input  tara_pkg::entry_flags_t                           q_flags,
	input  logic signed [31:0]                               q_sample,
	output logic                                             result_valid,
	input  logic                                             result_stall,
	output logic [31:0]                                      dest_index,
	output logic signed [31:0]                               value,
	output logic                                             last,
	output logic                                             error
);
	import tara_pkg::*;

	localparam int W1 = 2 * LENGTH_BITS;
	localparam int W2 = 3 * LENGTH_BITS;
	localparam int W3 = 4 * LENGTH_BITS;

	logic adv_s1;
	logic adv_s2;
	logic adv_s3;
	logic adv_s4;

	logic                   v_s1;
	logic [W1-1:0]          t1_s1;
	logic [LENGTH_BITS-1:0] dc2_s1;
	logic [LENGTH_BITS-1:0] dl2_s1;
	logic [LENGTH_BITS-1:0] dc3_s1;
	logic [LENGTH_BITS-1:0] dl3_s1;
	logic signed [63:0]     prod_s1;
	logic signed [31:0]     sample_s1;
	entry_flags_t           flags_s1;

	logic                   v_s2;
	logic [W2-1:0]          t2_s2;
	logic [LENGTH_BITS-1:0] dc3_s2;
	logic [LENGTH_BITS-1:0] dl3_s2;
	logic signed [31:0]     value_s2;
	entry_flags_t           flags_s2;

	logic                   v_s3;
	logic [W3-1:0]          t3_s3;
	logic signed [31:0]     value_s3;
	entry_flags_t           flags_s3;

	logic                   v_s4;
	logic [31:0]            dest_s4;
	logic signed [31:0]     value_s4;
	logic                   last_s4;
	logic                   error_s4;

	logic signed [63:0] rnd_sum;
	logic [33:0]        rnd_q;
	logic signed [31:0] sat_value;
	logic               ovf;
	logic [63:0]        idx_wide;

	// a stage takes new data when it is empty or its contents move on
	assign adv_s4 = !v_s4 || !result_stall;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign q_pop = q_valid && adv_s1;

	// Q1.30 product, round half up, saturate
	always_comb begin
		rnd_sum = prod_s1 + ROUND_HALF;
		rnd_q = rnd_sum[63:30];
		if (rnd_q[33:31] == 3'b000 || rnd_q[33:31] == 3'b111) begin
			sat_value = rnd_q[31:0];
		end else begin
			sat_value = rnd_q[33] ? VALUE_MIN : VALUE_MAX;
		end
	end

	generate
		if (INDEX_BITS < W3) begin : g_ovf
			assign ovf = |(t3_s3 >> INDEX_BITS);
		end else begin : g_no_ovf
			assign ovf = 1'b0;
		end
	endgenerate

	assign idx_wide = 64'(t3_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= q_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			t1_s1 <= W1'(q_dc[0]) * W1'(q_dl[1]) + W1'(q_dc[1]);
			dc2_s1 <= q_dc[2];
			dl2_s1 <= q_dl[2];
			dc3_s1 <= q_dc[3];
			dl3_s1 <= q_dl[3];
			prod_s1 <= 64'(q_sample) * 64'(scale);
			sample_s1 <= q_sample;
			flags_s1 <= q_flags;
		end
		if (adv_s2) begin
			t2_s2 <= W2'(t1_s1) * W2'(dl2_s1) + W2'(dc2_s1);
			dc3_s2 <= dc3_s1;
			dl3_s2 <= dl3_s1;
			value_s2 <= flags_s1.scale_en ? sat_value : sample_s1;
			flags_s2 <= flags_s1;
		end
		if (adv_s3) begin
			t3_s3 <= W3'(t2_s2) * W3'(dl3_s2) + W3'(dc3_s2);
			value_s3 <= value_s2;
			flags_s3 <= flags_s2;
		end
		if (adv_s4) begin
			dest_s4 <= (flags_s3.rot_err || ovf) ? '0 : idx_wide[31:0];
			error_s4 <= flags_s3.rot_err || ovf;
			value_s4 <= value_s3;
			last_s4 <= flags_s3.last;
		end
	end

	assign result_valid = v_s4;
	assign dest_index = dest_s4;
	assign value = value_s4;
	assign last = last_s4;
	assign error = error_s4;

	a_err_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |-> dest_index == '0)
		else $error("error result with a nonzero index");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv_s3 |=> v_s3 && $stable(t3_s3) && $stable(value_s3))
		else $error("blocked stage three lost its contents");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_s1)
		else $error("queue read did not land in stage one");

endmodule

// ===== rtl/tensor_axis_reorder_address.sv =====
// Top level of the tensor axis reorder address generator.
// Holds the register file and joins tara_front, tara_queue and tara_back (tara_pkg).
//
// Usage: tensor elements enter in row-major order on sample/sample_valid; a
// transfer happens when sample_valid is high and sample_stall is low. Each
// element yields one result (dest_index, value, last, error) on the result
// channel, taken when result_valid is high and result_stall is low.
// Registers are written through cfg_write_en/cfg_index/cfg_data while no
// element is in flight; any write to a listed register restarts the tensor.
// Path: a sample transfer is written into the queue, then passes three
// pipeline stages and then the result register.
// Throughput: one element per cycle unless the receiver stalls; the three
// chained index multiplies sit in separate stages, the value multiply in the first.
// Reset: registers take their default values, coordinates clear, queue and
// pipeline empty. When the receiver stalls, the result register holds, the
// pipeline fills, then the four-entry queue fills and sample_stall rises.
module tensor_axis_reorder_address #(
	parameter int RANK_LIMIT  = tara_pkg::RANK_LIMIT_DEF,
	parameter int LENGTH_BITS = tara_pkg::LENGTH_BITS_DEF,
	parameter int INDEX_BITS  = tara_pkg::INDEX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [tara_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tara_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [31:0]                 sample,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	output logic [31:0]                        dest_index,
	output logic signed [31:0]                 value,
	output logic                               last,
	output logic                               error,
	output logic                               result_valid,
	input  logic                               result_stall
);
	import tara_pkg::*;

	localparam int COORD_W = NUM_AXES * LENGTH_BITS;
	localparam int FLAGS_W = $bits(entry_flags_t);
	localparam int ENTRY_W = 32 + FLAGS_W + 2 * COORD_W;

	cfg_t cfg_q;
	logic cfg_clear;

	logic push;
	logic queue_full;
	logic queue_not_empty;
	logic queue_pop;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry;

	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] f_dc;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] f_dl;
	entry_flags_t                         f_flags;

	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] b_dc;
	logic [NUM_AXES-1:0][LENGTH_BITS-1:0] b_dl;
	entry_flags_t                         b_flags;
	logic signed [31:0]                   b_sample;

	always_comb begin
		cfg_clear = 1'b0;
		if (cfg_write_en) begin
			unique case (cfg_index) inside
				REG_MODE, REG_RANK, REG_AXIS_LENGTHS, REG_AXIS_ORDER,
				REG_REFLECT_MASK, REG_ROTATE_AXES, REG_SCALE: cfg_clear = 1'b1;
				default: cfg_clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_MODE:         cfg_q.mode <= mode_t'(cfg_data[1:0]);
				REG_RANK:         cfg_q.rank <= cfg_data[2:0];
				REG_AXIS_LENGTHS: cfg_q.axis_lengths <= cfg_data;
				REG_AXIS_ORDER:   cfg_q.axis_order <= cfg_data[7:0];
				REG_REFLECT_MASK: cfg_q.reflect_mask <= cfg_data[3:0];
				REG_ROTATE_AXES:  cfg_q.rotate_axes <= cfg_data[3:0];
				REG_SCALE:        cfg_q.scale <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	tara_front #(
		.RANK_LIMIT  (RANK_LIMIT),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_clear    (cfg_clear),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.queue_full   (queue_full),
		.push         (push),
		.dc           (f_dc),
		.dl           (f_dl),
		.flags        (f_flags)
	);

	assign wr_entry = {sample, f_flags, f_dl, f_dc};

	tara_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (wr_entry),
		.pop       (queue_pop),
		.rd_data   (rd_entry),
		.not_empty (queue_not_empty),
		.full      (queue_full)
	);

	assign {b_sample, b_flags, b_dl, b_dc} = rd_entry;

	tara_back #(
		.LENGTH_BITS (LENGTH_BITS),
		.INDEX_BITS  (INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (cfg_q.scale),
		.q_valid      (queue_not_empty),
		.q_pop        (queue_pop),
		.q_dc         (b_dc),
		.q_dl         (b_dl),
		.q_flags      (b_flags),
		.q_sample     (b_sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dest_index   (dest_index),
		.value        (value),
		.last         (last),
		.error        (error)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for tensor_axis_reorder_address: directed table, then random register settings
// and element streams, every result checked against a table value or an in-bench placement predictor.
// Depends on rtl/tara_pkg.sv and rtl/tensor_axis_reorder_address.sv.
module tb;
	import tara_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNLISTED = 3'd7;
	localparam int RANDOM_ELEMENTS = 1300;

	typedef struct packed {
		logic [31:0] dest_index;
		logic [31:0] value;
		logic        last;
		logic        error;
	} placement_t;

	typedef struct {
		bit                      is_write;
		logic [CFG_INDEX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0]   data;
		logic [31:0]             sample;
		bit                      typed;
		placement_t              want;
	} script_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BURST} stall_style_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic signed [31:0]       sample = '0;
	logic                     sample_valid = 1'b0;
	logic                     sample_stall;
	logic [31:0]              dest_index;
	logic signed [31:0]       value;
	logic                     last;
	logic                     error;
	logic                     result_valid;
	logic                     result_stall = 1'b0;

	// predictor copy of the register file and coordinate counters
	mode_t              cur_mode = MODE_PERMUTE;
	logic [2:0]         cur_rank = 3'd1;
	logic [63:0]        cur_lengths = 64'h0001_0001_0001_0001;
	logic [7:0]         cur_order = 8'd228;
	logic [3:0]         cur_reflect = 4'd0;
	logic [3:0]         cur_rotate = 4'd4;
	logic signed [31:0] cur_scale = 32'sh4000_0000;
	logic [15:0]        coord [NUM_AXES] = '{default: '0};

	placement_t   expected_placements [$];
	script_row_t  script [$];
	int           mismatches = 0;

	stall_style_t stall_style = STALL_NONE;
	int           stall_hold = 0;
	logic [4:0]   stall_phase = '0;

	tensor_axis_reorder_address i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.dest_index   (dest_index),
		.value        (value),
		.last         (last),
		.error        (error),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always #1 clk = ~clk;

	function automatic void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
		bit listed;
		listed = 1'b1;
		case (idx)
			REG_MODE:         cur_mode = mode_t'(data[1:0]);
			REG_RANK:         cur_rank = data[2:0];
			REG_AXIS_LENGTHS: cur_lengths = data;
			REG_AXIS_ORDER:   cur_order = data[7:0];
			REG_REFLECT_MASK: cur_reflect = data[3:0];
			REG_ROTATE_AXES:  cur_rotate = data[3:0];
			REG_SCALE:        cur_scale = data[31:0];
			default:          listed = 1'b0;
		endcase
		// any listed write starts a new tensor
		if (listed)
			for (int d = 0; d < NUM_AXES; d++)
				coord[d] = '0;
	endfunction

	function automatic placement_t place_element(logic signed [31:0] s);
		logic [63:0]        c [NUM_AXES];
		logic [63:0]        l [NUM_AXES];
		logic [63:0]        dc [NUM_AXES];
		logic [63:0]        dl [NUM_AXES];
		logic [63:0]        idx;
		logic signed [63:0] prod;
		logic signed [63:0] q;
		int                 r, d, p, a1, a2;
		bit                 err, fin, carry;
		placement_t         res;
		r = int'(cur_rank);
		if (r < 1)
			r = 1;
		if (r > RANK_LIMIT_DEF)
			r = RANK_LIMIT_DEF;
		err = 1'b0;
		fin = 1'b1;
		for (d = 0; d < NUM_AXES; d++) begin
			c[d] = (d < r) ? 64'(coord[d]) : 64'd0;
			l[d] = 64'd1;
			if (d < r && cur_lengths[16*d +: 16] != 16'd0)
				l[d] = 64'(cur_lengths[16*d +: 16]);
			if (c[d] >= l[d])
				c[d] = l[d] - 1;
			dc[d] = c[d];
			dl[d] = l[d];
		end
		a1 = int'(cur_rotate[1:0]);
		a2 = int'(cur_rotate[3:2]);
		case (cur_mode)
			MODE_PERMUTE: begin
				for (d = 0; d < r; d++) begin
					p = int'(cur_order[2*d +: 2]);
					if (p >= r)
						p = d;
					dc[d] = c[p];
					dl[d] = l[p];
				end
			end
			MODE_REFLECT: begin
				for (d = 0; d < r; d++)
					if (cur_reflect[d])
						dc[d] = l[d] - 1 - c[d];
			end
			MODE_ROT90: begin
				if (a1 < r && a2 < r && a1 != a2) begin
					if (l[a1] != l[a2]) begin
						err = 1'b1;
					end else begin
						dc[a1] = c[a2];
						dc[a2] = l[a2] - 1 - c[a1];
					end
				end
			end
			default: begin
				if (a1 < r && a2 < r) begin
					dc[a1] = l[a1] - 1 - c[a1];
					if (a2 != a1)
						dc[a2] = l[a2] - 1 - c[a2];
				end
			end
		endcase
		idx = '0;
		for (d = 0; d < r; d++)
			idx = idx * dl[d] + dc[d];
		if (idx[63:32] != 32'd0)
			err = 1'b1;
		for (d = 0; d < r; d++)
			if (c[d] != l[d] - 1)
				fin = 1'b0;
		if (cur_mode == MODE_PERMUTE || cur_mode == MODE_REFLECT) begin
			prod = 64'(s) * 64'(cur_scale);
			q = (prod + ROUND_HALF) >>> 30;
			if (q > 64'(VALUE_MAX))
				q = 64'(VALUE_MAX);
			else if (q < 64'(VALUE_MIN))
				q = 64'(VALUE_MIN);
			res.value = q[31:0];
		end else begin
			res.value = s;
		end
		res.dest_index = err ? 32'd0 : idx[31:0];
		res.last = fin;
		res.error = err;
		// row-major advance, last axis in use runs fastest
		carry = 1'b1;
		for (d = r - 1; d >= 0; d--) begin
			if (carry) begin
				if (c[d] + 1 >= l[d]) begin
					coord[d] = '0;
				end else begin
					coord[d] = 16'(c[d] + 1);
					carry = 1'b0;
				end
			end
		end
		return res;
	endfunction

	function automatic void add_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
		script_row_t row;
		row = '{is_write: 1'b1, reg_idx: idx, data: data, sample: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	function automatic void add_elem(logic [31:0] s);
		script_row_t row;
		row = '{is_write: 1'b0, reg_idx: '0, data: '0, sample: s, typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	function automatic void add_elem_want(logic [31:0] s, logic [31:0] dst, logic [31:0] val,
			logic lst, logic err);
		script_row_t row;
		row = '{is_write: 1'b0, reg_idx: '0, data: '0, sample: s, typed: 1'b1,
			want: '{dest_index: dst, value: val, last: lst, error: err}};
		script.push_back(row);
	endfunction

	function automatic logic [63:0] pick_reg_value(logic [CFG_INDEX_W-1:0] idx);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case (idx)
			REG_AXIS_LENGTHS: begin
				case ($urandom_range(0, 7))
					0: ;
					1: for (int k = 0; k < NUM_AXES; k++)
						v[16*k +: 16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
					default: for (int k = 0; k < NUM_AXES; k++)
						v[16*k +: 16] = 16'($urandom_range(0, 3));
				endcase
			end
			REG_SCALE: begin
				if ($urandom_range(0, 3) == 0)
					case ($urandom_range(0, 5))
						0: v[31:0] = 32'h4000_0000;
						1: v[31:0] = 32'hC000_0000;
						2: v[31:0] = 32'h8000_0000;
						3: v[31:0] = 32'h7FFF_FFFF;
						4: v[31:0] = 32'h0000_0000;
						default: v[31:0] = 32'h0000_0001;
					endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_sample();
		if ($urandom_range(0, 7) != 0)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h2000_0000;
			default: return 32'hE000_0000;
		endcase
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_config(idx, data);
	endtask

	task automatic send_element(logic [31:0] s, bit typed, placement_t want);
		placement_t predicted;
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		predicted = place_element(s);
		expected_placements.push_back(typed ? want : predicted);
	endtask

	// stop sending and wait until every pending result has come back
	task automatic drain(int settle);
		sample_valid <= 1'b0;
		do @(posedge clk); while (expected_placements.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_hold <= $urandom_range(40, 300);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		stall_phase <= stall_phase + 1'b1;
		case (stall_style)
			STALL_NONE:   result_stall <= 1'b0;
			STALL_COIN:   result_stall <= 1'($urandom_range(0, 1));
			STALL_SPARSE: result_stall <= ($urandom_range(0, 7) == 0);
			default:      result_stall <= (stall_phase < 5'd24);
		endcase
	end

	always @(posedge clk) begin
		placement_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_placements.size() == 0) begin
				note_mismatch("result transfer with nothing pending", dest_index, '0);
			end else begin
				want = expected_placements.pop_front();
				if (dest_index !== want.dest_index)
					note_mismatch("dest_index", dest_index, want.dest_index);
				if (value !== want.value)
					note_mismatch("value", value, want.value);
				if (last !== want.last)
					note_mismatch("last", 32'(last), 32'(want.last));
				if (error !== want.error)
					note_mismatch("error", 32'(error), 32'(want.error));
			end
		end
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		bit writing;
		int random_sent, n, gap, gap_max, burst_left, pause_at;

		// reset defaults: rank 1, unit lengths, scale 1.0
		add_elem_want(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
		add_elem_want(32'h8000_0000, 32'd0, 32'h8000_0000, 1'b1, 1'b0);
		// scale -1.0 with junk above bit 31: saturation on the most negative sample
		add_write(REG_SCALE, 64'hFFFF_FFFF_C000_0000);
		add_elem_want(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
		add_elem_want(32'h7FFF_FFFF, 32'd0, 32'h8000_0001, 1'b1, 1'b0);
		// tiny scale: round half up
		add_write(REG_SCALE, 64'd1);
		add_elem_want(32'h2000_0000, 32'd0, 32'd1, 1'b1, 1'b0);
		add_elem_want(32'hE000_0000, 32'd0, 32'd0, 1'b1, 1'b0);
		add_elem(32'hDFFF_FFFF);
		add_write(REG_SCALE, 64'h8000_0000);
		add_elem(32'h8000_0000);
		// 2x3 transpose; an unlisted write mid-tensor must not restart it
		add_write(REG_SCALE, 64'h4000_0000);
		add_write(REG_RANK, 64'd2);
		add_write(REG_AXIS_LENGTHS, 64'h0000_0000_0003_0002);
		add_write(REG_AXIS_ORDER, 64'hE1);
		for (int i = 0; i < 3; i++)
			add_elem($urandom);
		add_write(REG_UNLISTED, '1);
		for (int i = 0; i < 3; i++)
			add_elem($urandom);
		// all axes reversed on a huge tensor: index overflow
		add_write(REG_MODE, 64'(MODE_REFLECT));
		add_write(REG_RANK, 64'd3);
		add_write(REG_AXIS_LENGTHS, 64'h0000_FFFF_FFFF_FFFF);
		add_write(REG_REFLECT_MASK, 64'hF);
		add_elem_want(32'd12345, 32'd0, 32'd12345, 1'b0, 1'b1);
		add_write(REG_RANK, 64'd2);
		add_write(REG_AXIS_LENGTHS, 64'h0000_0000_0003_0002);
		add_write(REG_REFLECT_MASK, 64'h1);
		add_elem($urandom);
		add_elem($urandom);
		// quarter turn on unequal lengths flags error
		add_write(REG_MODE, 64'(MODE_ROT90));
		add_elem_want(32'h1234_5678, 32'd0, 32'h1234_5678, 1'b0, 1'b1);
		add_write(REG_AXIS_LENGTHS, 64'h0000_0000_0003_0003);
		add_elem($urandom);
		add_elem($urandom);
		// same axis twice, then half turn on it, then an axis outside the rank
		add_write(REG_ROTATE_AXES, 64'h5);
		add_elem($urandom);
		add_write(REG_MODE, 64'(MODE_ROT180));
		add_elem($urandom);
		add_write(REG_ROTATE_AXES, 64'hC);
		add_elem($urandom);
		// rank 0 and zero lengths act as one
		add_write(REG_RANK, 64'd0);
		add_write(REG_AXIS_LENGTHS, 64'd0);
		add_elem_want(32'h8000_0000, 32'd0, 32'h8000_0000, 1'b1, 1'b0);
		// rank 7 saturates to 4, reversed axis order
		add_write(REG_MODE, 64'(MODE_PERMUTE));
		add_write(REG_RANK, 64'd7);
		add_write(REG_AXIS_LENGTHS, 64'h0002_0002_0002_0002);
		add_write(REG_AXIS_ORDER, 64'h1B);
		add_elem($urandom);
		add_elem($urandom);
		// order entry outside the rank plus a repeated entry
		add_write(REG_RANK, 64'd3);
		add_write(REG_AXIS_ORDER, 64'h03);
		add_elem($urandom);
		add_elem($urandom);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		writing = 1'b0;
		foreach (script[i]) begin
			if (script[i].is_write) begin
				if (!writing)
					drain(2);
				write_reg(script[i].reg_idx, script[i].data);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_write_en <= 1'b0;
				writing = 1'b0;
				send_element(script[i].sample, script[i].typed, script[i].want);
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_ELEMENTS) begin
			drain(2);
			for (int i = 0; i < 7; i++)
				if ($urandom_range(0, 2) == 0)
					write_reg(3'(i), pick_reg_value(3'(i)));
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNLISTED, {$urandom, $urandom});
			cfg_write_en <= 1'b0;

			n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 50);
			gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : -1;
			for (int i = 0; i < n; i++) begin
				// idle time goes before a transfer, never after the last one
				if (i == pause_at) begin
					drain(0);
				end else if (burst_left == 0) begin
					gap = $urandom_range(0, gap_max);
					if (gap != 0) begin
						sample_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				if (burst_left == 0)
					burst_left = $urandom_range(1, 16);
				send_element(pick_sample(), 1'b0, '0);
				random_sent++;
				burst_left--;
			end
		end

		drain(8);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
